// File: design/midc_pkg.sv
package midc_pkg;

  localparam logic [7:0] STATUS_MIN  = 8'h80;
  localparam logic [7:0] ST_SOX      = 8'hF0;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONT     = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;
  localparam logic [7:0] ST_SENSE    = 8'hFE;
  localparam logic [7:0] ST_RESET    = 8'hFF;

  localparam logic [3:0] FAM_PROGRAM = 4'hC;
  localparam logic [3:0] FAM_CHPRESS = 4'hD;
  localparam logic [3:0] FAM_BEND    = 4'hE;

  localparam logic [1:0] SEEN_MAX = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_SHORT = 2'd1,
    VERDICT_BAD   = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    KIND_NOTE_OFF  = 4'd0,
    KIND_NOTE_ON   = 4'd1,
    KIND_POLY_AT   = 4'd2,
    KIND_CC        = 4'd3,
    KIND_PROGRAM   = 4'd4,
    KIND_CH_PRESS  = 4'd5,
    KIND_BEND      = 4'd6,
    KIND_SYSEX     = 4'd7,
    KIND_COMMON    = 4'd8,
    KIND_CLOCK     = 4'd9,
    KIND_START     = 4'd10,
    KIND_CONTINUE  = 4'd11,
    KIND_STOP      = 4'd12,
    KIND_SENSING   = 4'd13,
    KIND_RESET     = 4'd14,
    KIND_UNKNOWN   = 4'd15
  } kind_t;

  typedef struct packed {
    logic [7:0] status;
    logic [1:0] seen;
    logic [6:0] data1;
    logic [6:0] data2;
    logic       bad;
  } held_t;

  typedef struct packed {
    verdict_t    verdict;
    kind_t       kind;
    logic [3:0]  channel;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [1:0]  count;
    logic [13:0] combined;
    logic        comb_valid;
  } result_t;

endpackage

// File: design/midi1_message_classifier_top.sv
// MIDI 1.0 message classifier.
// Input channel: one message byte per word (in_byte), status byte first,
// with in_end_of_message set on the final byte of the framed message.
// Output channel: one result word per message, produced only for the final
// byte: verdict (ok, incomplete, malformed), message kind, channel, up to two
// 7-bit data bytes, data count and the 14-bit bend / song position value.
// On a failed verdict every other field reads zero.
// A final byte goes through the input register, then is decoded into the
// result register, which raises out_valid; it waits in the input register
// while an earlier result is still held for the receiver.
// Throughput: one byte per cycle while results are taken; non-final bytes only
// update the per-message state and never wait on the output side.
// A stalled receiver holds the result; the input register then holds a
// following final byte, and in_ready drops only if that byte must also wait.
// Reset (rst_n low, synchronous) empties both registers and clears the
// message state, so the next byte accepted is taken as a status byte.
module midi1_message_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_verdict,
  output logic [3:0]  out_message_kind,
  output logic [3:0]  out_channel_number,
  output logic [6:0]  out_first_data,
  output logic [6:0]  out_second_data,
  output logic [1:0]  out_data_count,
  output logic [13:0] out_combined_value,
  output logic        out_combined_valid
);
  import midc_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eom_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  result_t    res;
  held_t      held;
  logic       advance;
  logic       load;

  // a non-final byte never needs the output register
  assign advance  = s1_valid_r && (!s1_eom_r || !out_valid_r || out_ready);
  assign load     = advance && s1_eom_r;
  assign in_ready = !s1_valid_r || advance;

  midc_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (s1_byte_r),
    .eom     (s1_eom_r),
    .held    (held)
  );

  midc_decode u_decode (
    .byte_in (s1_byte_r),
    .held    (held),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (advance)         s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (load)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_eom_r  <= in_end_of_message;
    end
    if (load) out_res_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = out_res_r.verdict;
  assign out_message_kind   = out_res_r.kind;
  assign out_channel_number = out_res_r.channel;
  assign out_first_data     = out_res_r.data1;
  assign out_second_data    = out_res_r.data2;
  assign out_data_count     = out_res_r.count;
  assign out_combined_value = out_res_r.combined;
  assign out_combined_valid = out_res_r.comb_valid;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.verdict != VERDICT_OK |->
      out_res_r.kind == KIND_NOTE_OFF && out_res_r.count == 2'd0 &&
      out_res_r.combined == 14'd0 && !out_res_r.comb_valid)
    else $error("failed verdict with nonzero fields");

  a_rise_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_eom_r))
    else $error("result word without a final byte");

endmodule

// File: design/midc_state.sv
module midc_state (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      byte_in,
  input  logic            eom,
  output midc_pkg::held_t held
);
  import midc_pkg::*;

  held_t held_r, held_nxt;

  always_comb begin
    held_nxt = held_r;
    if (step) begin
      if (eom) begin
        held_nxt = '0;
      end else begin
        if (held_r.seen == 2'd0) begin
          held_nxt.status = byte_in;
        end else begin
          if (held_r.seen == 2'd1) held_nxt.data1 = byte_in[6:0];
          if (held_r.seen == 2'd2) held_nxt.data2 = byte_in[6:0];
          if (byte_in[7]) held_nxt.bad = 1'b1;
        end
        if (held_r.seen != SEEN_MAX) held_nxt.seen = held_r.seen + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign held = held_r;

  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    step && eom |=> held_r.seen == 2'd0 && !held_r.bad)
    else $error("message state not cleared after final word");

  a_bad_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    held_r.bad |-> held_r.seen >= 2'd2)
    else $error("bad data flag set without a data byte");

endmodule

// File: design/midc_decode.sv
module midc_decode (
  input  logic [7:0]        byte_in,
  input  midc_pkg::held_t   held,
  output midc_pkg::result_t res
);
  import midc_pkg::*;

  logic [7:0] st;
  logic [2:0] total;
  logic       bad;
  logic [6:0] a;
  logic [6:0] c;
  logic [1:0] expected;
  logic       cvalid;
  verdict_t   verdict;
  kind_t      kind;
  logic [3:0] chan;

  assign st    = (held.seen == 2'd0) ? byte_in : held.status;
  assign total = {1'b0, held.seen} + 3'd1;
  assign bad   = held.bad | ((held.seen != 2'd0) && byte_in[7] && (st != ST_SOX));
  assign a     = (held.seen == 2'd1) ? byte_in[6:0] : held.data1;
  assign c     = (held.seen == 2'd2) ? byte_in[6:0] : held.data2;

  always_comb begin
    expected = 2'd1;
    cvalid   = 1'b0;
    kind     = KIND_UNKNOWN;
    chan     = 4'd0;
    verdict  = VERDICT_OK;
    if (st < STATUS_MIN || st == ST_EOX) begin
      verdict = VERDICT_BAD;
    end else if (st == ST_SOX) begin
      kind = KIND_SYSEX;
      if (total < 3'd2 || byte_in != ST_EOX) verdict = VERDICT_SHORT;
      else if (held.bad) verdict = VERDICT_BAD;
    end else begin
      case (st) inside
        [8'h80:8'hEF]: begin
          kind     = kind_t'({1'b0, st[6:4]});
          chan     = st[3:0];
          expected = (st[7:4] == FAM_PROGRAM || st[7:4] == FAM_CHPRESS) ? 2'd2 : 2'd3;
          cvalid   = (st[7:4] == FAM_BEND);
        end
        ST_MTC, ST_SONG_SEL: begin
          kind     = KIND_COMMON;
          expected = 2'd2;
        end
        ST_SONG_POS: begin
          kind     = KIND_COMMON;
          expected = 2'd3;
          cvalid   = 1'b1;
        end
        ST_TUNE:  kind = KIND_COMMON;
        ST_CLOCK: kind = KIND_CLOCK;
        ST_START: kind = KIND_START;
        ST_CONT:  kind = KIND_CONTINUE;
        ST_STOP:  kind = KIND_STOP;
        ST_SENSE: kind = KIND_SENSING;
        ST_RESET: kind = KIND_RESET;
        default:  kind = KIND_UNKNOWN;
      endcase
      if (total < {1'b0, expected}) verdict = VERDICT_SHORT;
      else if (total != {1'b0, expected} || bad) verdict = VERDICT_BAD;
    end
  end

  always_comb begin
    res = '0;
    if (verdict != VERDICT_OK) begin
      res.verdict = verdict;
    end else begin
      res.verdict = VERDICT_OK;
      res.kind    = kind;
      res.channel = chan;
      if (st != ST_SOX) begin
        res.count = expected - 2'd1;
        if (expected > 2'd1) res.data1 = a;
        if (expected > 2'd2) res.data2 = c;
      end
      res.comb_valid = cvalid;
      if (cvalid) res.combined = {res.data2, res.data1};
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import midc_pkg::*;

  localparam logic [3:0] FAM_NOTE_OFF = 4'h8;
  localparam logic [3:0] FAM_NOTE_ON  = 4'h9;
  localparam logic [3:0] FAM_POLY_AT  = 4'hA;
  localparam logic [3:0] FAM_CC       = 4'hB;
  localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
  localparam logic [7:0] ST_UNDEF_F9  = 8'hF9;
  localparam logic [7:0] ST_UNDEF_FD  = 8'hFD;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_verdict;
  logic [3:0]  out_message_kind;
  logic [3:0]  out_channel_number;
  logic [6:0]  out_first_data;
  logic [6:0]  out_second_data;
  logic [1:0]  out_data_count;
  logic [13:0] out_combined_value;
  logic        out_combined_valid;

  // message state of the predictor
  logic [7:0] held_status = 8'h00;
  logic [1:0] held_count = 2'd0;
  logic [6:0] held_first = 7'd0;
  logic [6:0] held_second = 7'd0;
  logic       held_bad = 1'b0;

  result_t     expected_results[$];
  logic [7:0]  msg_q[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          bytes_sent = 0;
  int          fail_count = 0;
  int          stall_cycles = 0;

  midi1_message_classifier_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .in_end_of_message  (in_end_of_message),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_message_kind   (out_message_kind),
    .out_channel_number (out_channel_number),
    .out_first_data     (out_first_data),
    .out_second_data    (out_second_data),
    .out_data_count     (out_data_count),
    .out_combined_value (out_combined_value),
    .out_combined_valid (out_combined_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit classify_byte(input logic [7:0] b, input logic eom,
                                       output result_t r);
    logic [7:0] st;
    logic [2:0] total;
    logic [1:0] need;
    logic       bad;
    logic [6:0] a;
    logic [6:0] c;
    r = '0;
    if (!eom) begin
      if (held_count == 2'd0) begin
        held_status = b;
      end else begin
        if (held_count == 2'd1) held_first = b[6:0];
        if (held_count == 2'd2) held_second = b[6:0];
        if (b[7]) held_bad = 1'b1;
      end
      if (held_count != SEEN_MAX) held_count = held_count + 2'd1;
      return 1'b0;
    end
    st = (held_count == 2'd0) ? b : held_status;
    total = {1'b0, held_count} + 3'd1;
    bad = held_bad || (held_count != 2'd0 && b[7] && st != ST_SOX);
    a = (held_count == 2'd1) ? b[6:0] : held_first;
    c = (held_count == 2'd2) ? b[6:0] : held_second;
    need = 2'd1;
    if (st < STATUS_MIN || st == ST_EOX) begin
      r.verdict = VERDICT_BAD;
    end else if (st == ST_SOX) begin
      if (total < 3'd2 || b != ST_EOX) r.verdict = VERDICT_SHORT;
      else if (held_bad) r.verdict = VERDICT_BAD;
      else r.kind = KIND_SYSEX;
    end else begin
      if (st < ST_SOX) begin
        need = (st[7:4] == FAM_PROGRAM || st[7:4] == FAM_CHPRESS) ? 2'd2 : 2'd3;
        r.kind = kind_t'(st[7:4] - 4'd8);
        r.channel = st[3:0];
        r.comb_valid = (st[7:4] == FAM_BEND);
      end else begin
        case (st)
          ST_MTC, ST_SONG_SEL: begin
            need = 2'd2;
            r.kind = KIND_COMMON;
          end
          ST_SONG_POS: begin
            need = 2'd3;
            r.kind = KIND_COMMON;
            r.comb_valid = 1'b1;
          end
          ST_TUNE:  r.kind = KIND_COMMON;
          ST_CLOCK: r.kind = KIND_CLOCK;
          ST_START: r.kind = KIND_START;
          ST_CONT:  r.kind = KIND_CONTINUE;
          ST_STOP:  r.kind = KIND_STOP;
          ST_SENSE: r.kind = KIND_SENSING;
          ST_RESET: r.kind = KIND_RESET;
          default:  r.kind = KIND_UNKNOWN;
        endcase
      end
      if (total < {1'b0, need}) begin
        r.verdict = VERDICT_SHORT;
      end else if (total != {1'b0, need} || bad) begin
        r.verdict = VERDICT_BAD;
      end else begin
        r.count = need - 2'd1;
        if (need > 2'd1) r.data1 = a;
        if (need > 2'd2) r.data2 = c;
        if (r.comb_valid) r.combined = {r.data2, r.data1};
      end
    end
    if (r.verdict != VERDICT_OK) begin
      r = '0;
      r.verdict = (st < STATUS_MIN || st == ST_EOX || (st != ST_SOX && total > {1'b0, need})
                   || (st != ST_SOX && total == {1'b0, need} && bad)
                   || (st == ST_SOX && total >= 3'd2 && b == ST_EOX && held_bad))
                  ? VERDICT_BAD : VERDICT_SHORT;
    end
    held_status = 8'h00;
    held_count = 2'd0;
    held_first = 7'd0;
    held_second = 7'd0;
    held_bad = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eom);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (classify_byte(b, eom, r)) expected_results.push_back(r);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  task automatic test_channel_voice();
    msg_q = '{{FAM_NOTE_OFF, 4'h0}, 8'h00, 8'h00};     send_message();
    msg_q = '{{FAM_NOTE_ON, 4'hF}, 8'h7F, 8'h7F};      send_message();
    msg_q = '{{FAM_POLY_AT, 4'h5}, 8'h40, 8'h01};      send_message();
    msg_q = '{{FAM_CC, 4'h3}, 8'h07, 8'h64};           send_message();
    msg_q = '{{FAM_PROGRAM, 4'h0}, 8'h00};             send_message();
    msg_q = '{{FAM_CHPRESS, 4'hF}, 8'h7F};             send_message();
    msg_q = '{{FAM_BEND, 4'h0}, 8'h00, 8'h00};         send_message();
    msg_q = '{{FAM_BEND, 4'hF}, 8'h7F, 8'h7F};         send_message();
  endtask

  task automatic test_system_messages();
    msg_q = '{ST_MTC, 8'h55};                          send_message();
    msg_q = '{ST_SONG_POS, 8'h7F, 8'h7F};              send_message();
    msg_q = '{ST_SONG_SEL, 8'h02};                     send_message();
    msg_q = '{ST_TUNE};                                send_message();
    msg_q = '{ST_CLOCK};                               send_message();
    msg_q = '{ST_START};                               send_message();
    msg_q = '{ST_CONT};                                send_message();
    msg_q = '{ST_STOP};                                send_message();
    msg_q = '{ST_SENSE};                               send_message();
    msg_q = '{ST_RESET};                               send_message();
    msg_q = '{ST_UNDEF_F4};                            send_message();
    msg_q = '{ST_UNDEF_F5};                            send_message();
    msg_q = '{ST_UNDEF_F9};                            send_message();
    msg_q = '{ST_UNDEF_FD};                            send_message();
    msg_q = '{ST_SOX, ST_EOX};                         send_message();
    msg_q = '{ST_SOX, 8'h01, 8'h7F, ST_EOX};           send_message();
  endtask

  task automatic test_framing_errors();
    msg_q = '{8'h00};                                  send_message();
    msg_q = '{8'h7F, 8'h10, 8'h20};                    send_message();
    msg_q = '{ST_EOX};                                 send_message();
    msg_q = '{ST_EOX, 8'h01};                          send_message();
    msg_q = '{ST_SOX};                                 send_message();
    msg_q = '{ST_SOX, 8'h01, 8'h02};                   send_message();
    msg_q = '{ST_SOX, 8'h81, ST_EOX};                  send_message();
    msg_q = '{ST_SOX, ST_SOX, ST_EOX};                 send_message();
    msg_q = '{{FAM_NOTE_ON, 4'h1}, 8'h40};             send_message();
    msg_q = '{{FAM_NOTE_ON, 4'h1}, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
    send_message();
    msg_q = '{{FAM_NOTE_ON, 4'h2}, 8'hC0, 8'h40};      send_message();
    msg_q = '{{FAM_NOTE_ON, 4'h2}, 8'h40, 8'hC0};      send_message();
    msg_q = '{{FAM_PROGRAM, 4'h5}};                    send_message();
    msg_q = '{{FAM_PROGRAM, 4'h5}, 8'h10, 8'h10};      send_message();
    msg_q = '{ST_CLOCK, 8'h00};                        send_message();
    msg_q = '{ST_SONG_POS, 8'h7F};                     send_message();
  endtask

  task automatic build_random_message();
    int unsigned pick;
    int unsigned n;
    int unsigned idx;
    logic [7:0]  st;
    msg_q.delete();
    pick = $urandom_range(99);
    if (pick < 15) begin
      n = $urandom_range(6, 1);
      repeat (n) msg_q.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(9))
      6: begin
        case ($urandom_range(5))
          0: begin st = ST_MTC;      n = 1; end
          1: begin st = ST_SONG_POS; n = 2; end
          2: begin st = ST_SONG_SEL; n = 1; end
          3: begin st = ST_TUNE;     n = 0; end
          4: begin st = ST_UNDEF_F4; n = 0; end
          default: begin st = ST_UNDEF_F5; n = 0; end
        endcase
      end
      7: begin
        st = ST_CLOCK + 8'($urandom_range(7));
        n = 0;
      end
      8, 9: begin
        st = ST_SOX;
        n = $urandom_range(6);
      end
      default: begin
        st = {4'($urandom_range(FAM_BEND, FAM_NOTE_OFF)), 4'($urandom)};
        n = (st[7:4] == FAM_PROGRAM || st[7:4] == FAM_CHPRESS) ? 1 : 2;
      end
    endcase
    msg_q.push_back(st);
    repeat (n) msg_q.push_back({1'b0, 7'($urandom)});
    if (st == ST_SOX) msg_q.push_back(ST_EOX);
    if (pick < 35) begin
      case ($urandom_range(3))
        0: begin
          if (msg_q.size() > 1) begin
            idx = $urandom_range(msg_q.size() - 1, 1);
            msg_q[idx] = msg_q[idx] | STATUS_MIN;
          end
        end
        1: if (msg_q.size() > 1) void'(msg_q.pop_back());
        2: msg_q.push_back({1'b0, 7'($urandom)});
        default: msg_q[0] = 8'($urandom);
      endcase
    end
  endtask

  task automatic test_random(input int s_idle, input int r_idle, input int n_bytes);
    int start;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      build_random_message();
      send_message();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result word, expected none, actual verdict %0d kind %0d",
                 $time, out_verdict, out_message_kind);
      end else begin
        exp_r = expected_results.pop_front();
        check_field("verdict", exp_r.verdict, out_verdict);
        check_field("message_kind", exp_r.kind, out_message_kind);
        check_field("channel_number", exp_r.channel, out_channel_number);
        check_field("first_data", exp_r.data1, out_first_data);
        check_field("second_data", exp_r.data2, out_second_data);
        check_field("data_count", exp_r.count, out_data_count);
        check_field("combined_value", exp_r.combined, out_combined_value);
        check_field("combined_valid", exp_r.comb_valid, out_combined_valid);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("** midi1_message_classifier_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 34;
    recv_idle_pct = 81;
    test_channel_voice();
    test_system_messages();
    test_framing_errors();
    test_random(34, 81, 290);
    test_random(81, 34, 290);
    test_random(0, 0, 290);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      fail_count++;
      $display("%0t: results still expected, expected 0, actual %0d",
               $time, expected_results.size());
    end
    if (fail_count == 0) begin
      $display("** midi1_message_classifier_top: PASSED **");
    end else begin
      $display("** midi1_message_classifier_top: FAILED **");
    end
    $finish;
  end

endmodule
